FILE: src/sha256_pkg.sv
// Shared types, constants and round functions for the SHA-256 stream hasher.
package sha256_pkg;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       byte_present;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  // Command from the front part to the back part
  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       is_end;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FOLD,
    ST_PAD,
    ST_EMIT
  } core_state_t;

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    return k[i];
  endfunction

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

FILE: src/sha256_front.sv
// Input side: accepts items into a short command queue.
module sha256_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  sha256_pkg::in_item_t  in_item,
  output logic                  cmd_valid,
  output sha256_pkg::cmd_t      cmd,
  input  logic                  cmd_take
);
  import sha256_pkg::*;

  cmd_t       slot [2];
  logic [1:0] count;
  logic       wp;
  logic       rp;
  logic       acc;
  logic       keep;

  assign full      = count == 2'd2;
  assign acc       = push && !full;
  // drop items that carry neither a byte nor an end mark
  assign keep      = in_item.byte_present || in_item.end_of_message;
  assign cmd_valid = count != 2'd0;
  assign cmd       = slot[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
      wp    <= 1'b0;
      rp    <= 1'b0;
    end else begin
      if (acc && keep) begin
        slot[wp] <= '{data: in_item.msg_byte, has_byte: in_item.byte_present,
                      is_end: in_item.end_of_message};
        wp <= ~wp;
      end
      if (cmd_take) rp <= ~rp;
      count <= count + {1'b0, acc && keep} - {1'b0, cmd_take};
    end
  end
endmodule

FILE: src/sha256_core.sv
// Back side: block buffer, message schedule, round unit, padding and digest.
module sha256_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  input  sha256_pkg::cmd_t      cmd,
  output logic                  cmd_take,
  output logic                  empty,
  input  logic                  pop,
  output sha256_pkg::out_item_t out_item
);
  import sha256_pkg::*;

  core_state_t state, state_next;
  logic [31:0] h [8];
  logic [31:0] v [8];
  logic [31:0] w [16];
  logic [5:0]  fill;
  logic [60:0] total;
  logic [5:0]  rnd;
  logic        ending;    // padding in progress
  logic        mark_due;  // end arrived with a byte, marker still to write
  logic        len_ok;    // length goes into bytes 56..63 of this block
  logic        len_done;  // length block absorbed, emit next
  logic [2:0]  oidx;

  logic [7:0]  pad_byte;
  logic [63:0] bits;
  logic        byte_wr;
  logic [7:0]  wr_byte;
  logic [31:0] t1, t2, s0, s1, wn;
  logic [2:0]  lenk;

  assign bits = {total, 3'b000};
  assign lenk = fill[2:0];

  always_comb begin
    if (mark_due)
      pad_byte = PAD_MARK;
    else if (len_ok && fill >= LEN_POS)
      pad_byte = bits[{3'd7 - lenk, 3'b000} +: 8];
    else
      pad_byte = 8'h00;
  end

  // round datapath
  always_comb begin
    t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
       + ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_k(rnd) + w[0];
    t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
       + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
    s0 = ror32(w[1], 7) ^ ror32(w[1], 18) ^ (w[1] >> 3);
    s1 = ror32(w[14], 17) ^ ror32(w[14], 19) ^ (w[14] >> 10);
    wn = w[0] + s0 + w[9] + s1;
  end

  always_comb begin
    state_next = state;
    cmd_take   = 1'b0;
    byte_wr    = 1'b0;
    wr_byte    = cmd.data;
    empty      = 1'b1;
    case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_take = 1'b1;
          byte_wr  = 1'b1;
          // an end without a byte writes the marker right away
          if (!cmd.has_byte) wr_byte = PAD_MARK;
          if (fill == 6'd63) state_next = ST_ROUND;
          else if (cmd.is_end) state_next = ST_PAD;
        end
      end
      ST_PAD: begin
        byte_wr = 1'b1;
        wr_byte = pad_byte;
        if (fill == 6'd63) state_next = ST_ROUND;
      end
      ST_ROUND: if (rnd == 6'd63) state_next = ST_FOLD;
      ST_FOLD: begin
        if (len_done) state_next = ST_EMIT;
        else if (ending) state_next = ST_PAD;
        else state_next = ST_IDLE;
      end
      ST_EMIT: begin
        empty = 1'b0;
        if (pop && oidx == 3'd7) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign out_item = '{digest_word: h[oidx], word_index: oidx, last_word: oidx == 3'd7};

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) h[i] <= INIT_H[i];
      fill     <= '0;
      total    <= '0;
      rnd      <= '0;
      ending   <= 1'b0;
      mark_due <= 1'b0;
      len_ok   <= 1'b0;
      len_done <= 1'b0;
      oidx     <= '0;
    end else begin
      if (byte_wr) begin
        // write each byte into the schedule window at its fill position, big-endian
        w[fill[5:2]][{2'd3 - fill[1:0], 3'b000} +: 8] <= wr_byte;
        fill <= fill + 6'd1;
        if (state == ST_IDLE) begin
          if (cmd.has_byte) total <= total + 61'd1;
          if (cmd.is_end) ending <= 1'b1;
          if (cmd.has_byte && cmd.is_end) mark_due <= 1'b1;
        end
        // a marker below byte 56 leaves room for the length in this block
        if (((state == ST_IDLE && !cmd.has_byte) || (state == ST_PAD && mark_due))
            && fill < LEN_POS)
          len_ok <= 1'b1;
        if (state == ST_PAD) mark_due <= 1'b0;
        if (state == ST_PAD && fill == 6'd63) len_done <= len_ok;
      end
      // a block that starts after the marker always carries the length
      if (state == ST_FOLD && ending) len_ok <= 1'b1;
      if (state_next == ST_ROUND && state != ST_ROUND) begin
        for (int i = 0; i < 8; i++) v[i] <= h[i];
        rnd <= '0;
      end
      if (state == ST_ROUND) begin
        for (int i = 0; i < 15; i++) w[i] <= w[i + 1];
        w[15] <= wn;
        v[0] <= t1 + t2;
        v[1] <= v[0];
        v[2] <= v[1];
        v[3] <= v[2];
        v[4] <= v[3] + t1;
        v[5] <= v[4];
        v[6] <= v[5];
        v[7] <= v[6];
        rnd  <= rnd + 6'd1;
      end
      if (state == ST_FOLD)
        for (int i = 0; i < 8; i++) h[i] <= h[i] + v[i];
      if (state == ST_EMIT && pop) begin
        oidx <= oidx + 3'd1;
        if (oidx == 3'd7) begin
          for (int i = 0; i < 8; i++) h[i] <= INIT_H[i];
          fill     <= '0;
          total    <= '0;
          ending   <= 1'b0;
          mark_due <= 1'b0;
          len_ok   <= 1'b0;
          len_done <= 1'b0;
        end
      end
    end
  end
endmodule

FILE: src/sha256_stream_hasher.sv
// Top level of the streaming SHA-256 hasher.
// Usage:
//   Input channel: push/full with one in_item per transfer (a byte, a
//   byte-present flag, and an end mark). Items with neither byte nor end
//   are accepted and dropped.
//   Result channel: empty/pop; after an end mark the eight digest words
//   appear in order, word 0 most significant, last_word set on word 7.
// Timing:
//   The back part takes one queued byte per cycle while in its idle state;
//   every 64th byte starts a compression of 64 rounds plus a fold step on
//   the single round unit, during which no bytes are taken. An end mark adds
//   the padding bytes one per cycle and one or two compressions; the eight
//   digest words then appear and follow one per cycle while pop is high.
//   A two-entry queue decouples input from the back part.
// Reset: rst clears queue, counts and loads the initial hash values.
// Stall: while results wait, the back part holds; the queue fills and then
//   full rises until pop drains the digest.
module sha256_stream_hasher (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  sha256_pkg::in_item_t  in_item,
  output logic                  empty,
  input  logic                  pop,
  output sha256_pkg::out_item_t out_item
);
  import sha256_pkg::*;

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_take;

  sha256_front u_front (
    .clk, .rst, .push, .full, .in_item,
    .cmd_valid, .cmd, .cmd_take
  );

  sha256_core u_core (
    .clk, .rst, .cmd_valid, .cmd, .cmd_take,
    .empty, .pop, .out_item
  );
endmodule

FILE: src/sha256_checker.sv
// Port-level checks for the SHA-256 hasher and their binding.
module sha256_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  full,
  input logic                  empty,
  input logic                  pop,
  input sha256_pkg::out_item_t out_item
);
  a_rst_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("results after reset");
  a_known: assert property (@(posedge clk) disable iff (rst)
    !$isunknown({full, empty}))
    else $error("unknown handshake flag");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_item)))
    else $error("result changed while stalled");
  a_next: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && !out_item.last_word) |=>
      (!empty && out_item.word_index == $past(out_item.word_index) + 3'd1))
    else $error("digest words out of order");
  a_last: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (out_item.last_word == (out_item.word_index == 3'd7)))
    else $error("last_word mismatch");
endmodule

bind sha256_stream_hasher sha256_checker u_checker (
  .clk, .rst, .full, .empty, .pop, .out_item
);
